// ===== hw/rtl/csc_pkg.sv =====
package csc_pkg;

    // Character codes the lexer reacts to.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Input item kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Lexer mode, one-hot.
    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_STRING = 4'b0010,
        MODE_LINE   = 4'b0100,
        MODE_BLOCK  = 4'b1000
    } mode_t;

    // One result beat as it travels through the queue.
    typedef struct packed {
        logic [7:0] byte_val;
        logic       end_mark;
    } result_t;

    // Results produced by one accepted item (zero, one or two).
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Head of the queue as seen by the output stage.
    typedef struct packed {
        logic    valid;
        result_t data;
    } head_t;

    // Whitespace: space and the control range from tab to carriage return.
    function automatic logic is_ws(input logic [7:0] b);
        is_ws = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

// ===== hw/rtl/comment_strip_space_collapse.sv =====
// Byte-stream source preprocessor: whitespace runs collapse to one space,
// double-quoted strings pass unchanged, line and block comments are removed,
// and an end beat flushes any held slash and emits an end marker (end_mark=1,
// byte_out=0) before returning to the reset state. The lexer takes one input
// beat per cycle while in_ready is high and writes its zero to two result
// bytes into a small queue; the output register drains that queue at one
// result per cycle while out_ready is high. Input is therefore sustained at
// one beat per cycle while each beat yields at most one result; beats that
// yield two (a slash released together with the following byte) are paid for
// by the output port, which sets the long-run rate at one result per cycle.
// in_ready drops when the queue lacks room for two results.
// QUEUE_DEPTH must be a power of two, at least 4.
module comment_strip_space_collapse
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] byte_out,
    output logic       end_mark
);

    csc_pkg::push_t push;
    csc_pkg::head_t head;
    logic           room;
    logic           pop;
    logic           accept;

    assign in_ready = room;
    assign accept   = in_valid && room;

    // Front: lexer and classifier.
    csc_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .kind    (kind),
        .byte_in (byte_in),
        .push    (push)
    );

    // Queue between lexer and output stage.
    csc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .room  (room),
        .head  (head)
    );

    // Back: output register.
    csc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .byte_out  (byte_out),
        .end_mark  (end_mark)
    );

endmodule

// ===== hw/rtl/csc_front.sv =====
module csc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                kind,
    input  logic [7:0]          byte_in,
    output csc_pkg::push_t      push
);

    csc_pkg::mode_t mode_reg, mode_next;
    logic           held_reg, held_next;
    logic           star_reg, star_next;
    logic           space_reg, space_next;

    csc_pkg::result_t slash_res, space_res, byte_res, end_res;

    assign slash_res = '{byte_val: csc_pkg::CH_SLASH, end_mark: 1'b0};
    assign space_res = '{byte_val: csc_pkg::CH_SPACE, end_mark: 1'b0};
    assign byte_res  = '{byte_val: byte_in, end_mark: 1'b0};
    assign end_res   = '{byte_val: 8'h00, end_mark: 1'b1};

    // Classify the byte against the current mode and pick up to two results.
    always_comb
    begin
        mode_next   = mode_reg;
        held_next   = held_reg;
        star_next   = star_reg;
        space_next  = space_reg;
        push.count  = 2'd0;
        push.first  = byte_res;
        push.second = byte_res;

        if (kind == csc_pkg::KIND_END)
        begin
            // Flush a held slash, then mark the end and return to reset state.
            if (held_reg)
            begin
                push.first  = slash_res;
                push.second = end_res;
                push.count  = 2'd2;
            end
            else
            begin
                push.first = end_res;
                push.count = 2'd1;
            end
            mode_next  = csc_pkg::MODE_NORMAL;
            held_next  = 1'b0;
            star_next  = 1'b0;
            space_next = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                csc_pkg::MODE_STRING:
                begin
                    push.first = byte_res;
                    push.count = 2'd1;
                    space_next = 1'b0;
                    if (byte_in == csc_pkg::CH_QUOTE)
                    begin
                        mode_next = csc_pkg::MODE_NORMAL;
                    end
                end
                csc_pkg::MODE_LINE:
                begin
                    // A newline closes the comment and counts as whitespace.
                    if (byte_in == csc_pkg::CH_NL)
                    begin
                        mode_next = csc_pkg::MODE_NORMAL;
                        if (!space_reg)
                        begin
                            push.first = space_res;
                            push.count = 2'd1;
                            space_next = 1'b1;
                        end
                    end
                end
                csc_pkg::MODE_BLOCK:
                begin
                    if (star_reg && (byte_in == csc_pkg::CH_SLASH))
                    begin
                        mode_next = csc_pkg::MODE_NORMAL;
                        star_next = 1'b0;
                    end
                    else
                    begin
                        star_next = (byte_in == csc_pkg::CH_STAR);
                    end
                end
                default:
                begin
                    if (csc_pkg::is_ws(byte_in))
                    begin
                        // A flushed slash clears the space flag, so a space follows.
                        if (held_reg)
                        begin
                            push.first  = slash_res;
                            push.second = space_res;
                            push.count  = 2'd2;
                            held_next   = 1'b0;
                            space_next  = 1'b1;
                        end
                        else if (!space_reg)
                        begin
                            push.first = space_res;
                            push.count = 2'd1;
                            space_next = 1'b1;
                        end
                    end
                    else if (byte_in == csc_pkg::CH_SLASH)
                    begin
                        if (held_reg)
                        begin
                            held_next = 1'b0;
                            mode_next = csc_pkg::MODE_LINE;
                        end
                        else
                        begin
                            held_next = 1'b1;
                        end
                    end
                    else if ((byte_in == csc_pkg::CH_STAR) && held_reg)
                    begin
                        held_next = 1'b0;
                        star_next = 1'b0;
                        mode_next = csc_pkg::MODE_BLOCK;
                    end
                    else
                    begin
                        if (held_reg)
                        begin
                            push.first  = slash_res;
                            push.second = byte_res;
                            push.count  = 2'd2;
                            held_next   = 1'b0;
                        end
                        else
                        begin
                            push.first = byte_res;
                            push.count = 2'd1;
                        end
                        space_next = 1'b0;
                        if (byte_in == csc_pkg::CH_QUOTE)
                        begin
                            mode_next = csc_pkg::MODE_STRING;
                        end
                    end
                end
            endcase
        end

        if (!accept)
        begin
            push.count = 2'd0;
        end
    end

    // Lexer state advances only on an accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= csc_pkg::MODE_NORMAL;
            held_reg  <= 1'b0;
            star_reg  <= 1'b0;
            space_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            star_reg  <= star_next;
            space_reg <= space_next;
        end
    end

endmodule

// ===== hw/rtl/csc_queue.sv =====
module csc_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  csc_pkg::push_t push,
    input  logic           pop,
    output logic           room,
    output csc_pkg::head_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    csc_pkg::result_t   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    // Room for a full two-result item, judged on the registered fill level.
    assign room = (count_reg <= CNT_W'(DEPTH - 2));

    assign head.valid = (count_reg != '0);
    assign head.data  = mem[rd_ptr_reg];

    // Pointer and fill-level bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage: up to two consecutive entries written per beat.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

// ===== hw/rtl/csc_back.sv =====
module csc_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  csc_pkg::head_t head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     byte_out,
    output logic           end_mark
);

    logic             valid_reg;
    csc_pkg::result_t data_reg;
    logic             load;

    // Refill the output register whenever it is empty or being drained.
    assign load = head.valid && (!valid_reg || out_ready);
    assign pop  = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || out_ready)
        begin
            valid_reg <= head.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= head.data;
        end
    end

    assign out_valid = valid_reg;
    assign byte_out  = data_reg.byte_val;
    assign end_mark  = data_reg.end_mark;

endmodule

// ===== test/comment_strip_space_collapse_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the comment stripper, predicts the stripped text for
// every accepted input beat and compares each accepted output beat against it.
module comment_strip_space_collapse_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       kind,
    input  logic [7:0] byte_in,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] byte_out,
    input  logic       end_mark,
    output int         fail_count,
    output int         pending
);

    // One predicted output beat.
    typedef struct packed {
        logic [7:0] text;
        logic       marker;
    } text_beat_t;

    text_beat_t stripped_text[$];

    // Lexer state of the prediction.
    csc_pkg::mode_t lex_mode;
    logic           slash_held;
    logic           star_prev;
    logic           last_space;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == csc_pkg::CH_SPACE) || ((b >= csc_pkg::CH_TAB) && (b <= csc_pkg::CH_CR));
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic clear_lexer();
        lex_mode   = csc_pkg::MODE_NORMAL;
        slash_held = 1'b0;
        star_prev  = 1'b0;
        last_space = 1'b0;
    endtask

    // Append one predicted beat at the tail of the expected stream.
    task automatic queue_beat(input logic [7:0] b, input logic m);
        text_beat_t beat;
        beat.text     = b;
        beat.marker   = m;
        stripped_text = {stripped_text, beat};
    endtask

    task automatic push_text(input logic [7:0] b);
        queue_beat(b, 1'b0);
        last_space = 1'b0;
    endtask

    // A held slash turned out not to open a comment, so it goes out as text.
    task automatic release_slash();
        if (slash_held)
        begin
            slash_held = 1'b0;
            push_text(csc_pkg::CH_SLASH);
        end
    endtask

    // Whitespace runs collapse into a single space.
    task automatic push_space();
        if (!last_space)
        begin
            queue_beat(csc_pkg::CH_SPACE, 1'b0);
            last_space = 1'b1;
        end
    endtask

    // Advance the prediction by one input beat.
    task automatic strip_beat(input logic k, input logic [7:0] b);
        if (k == csc_pkg::KIND_END)
        begin
            release_slash();
            queue_beat(8'h00, 1'b1);
            clear_lexer();
        end
        else
        begin
            case (lex_mode)
                csc_pkg::MODE_STRING:
                begin
                    push_text(b);
                    if (b == csc_pkg::CH_QUOTE)
                        lex_mode = csc_pkg::MODE_NORMAL;
                end
                csc_pkg::MODE_LINE:
                begin
                    // Only a newline closes a line comment; it then acts as whitespace.
                    if (b == csc_pkg::CH_NL)
                    begin
                        lex_mode = csc_pkg::MODE_NORMAL;
                        push_space();
                    end
                end
                csc_pkg::MODE_BLOCK:
                begin
                    if (star_prev && (b == csc_pkg::CH_SLASH))
                    begin
                        lex_mode  = csc_pkg::MODE_NORMAL;
                        star_prev = 1'b0;
                    end
                    else
                    begin
                        star_prev = (b == csc_pkg::CH_STAR);
                    end
                end
                default:
                begin
                    if (is_blank(b))
                    begin
                        release_slash();
                        push_space();
                    end
                    else if (b == csc_pkg::CH_SLASH)
                    begin
                        if (slash_held)
                        begin
                            slash_held = 1'b0;
                            lex_mode   = csc_pkg::MODE_LINE;
                        end
                        else
                        begin
                            slash_held = 1'b1;
                        end
                    end
                    else if ((b == csc_pkg::CH_STAR) && slash_held)
                    begin
                        slash_held = 1'b0;
                        star_prev  = 1'b0;
                        lex_mode   = csc_pkg::MODE_BLOCK;
                    end
                    else
                    begin
                        release_slash();
                        push_text(b);
                        if (b == csc_pkg::CH_QUOTE)
                            lex_mode = csc_pkg::MODE_STRING;
                    end
                end
            endcase
        end
    endtask

    // Sample both channels at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        text_beat_t want;
        if (!rst_n)
        begin
            clear_lexer();
            stripped_text.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                strip_beat(kind, byte_in);
            if (out_valid && out_ready)
            begin
                if (stripped_text.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat byte_out=%02h end_mark=%0b",
                                              byte_out, end_mark));
                end
                else
                begin
                    want = stripped_text.pop_front();
                    if (byte_out !== want.text)
                        report_mismatch($sformatf("byte_out=%02h, predicted %02h",
                                                  byte_out, want.text));
                    if (end_mark !== want.marker)
                        report_mismatch($sformatf("end_mark=%0b, predicted %0b",
                                                  end_mark, want.marker));
                end
            end
            pending = stripped_text.size();
        end
    end

endmodule

// ===== test/comment_strip_space_collapse_tb.sv =====
`timescale 1ns / 1ps

module comment_strip_space_collapse_tb;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       kind      = csc_pkg::KIND_DATA;
    logic [7:0] byte_in   = 8'h00;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] byte_out;
    logic       end_mark;

    int fail_count;
    int pending;
    int beats_sent  = 0;
    int send_run    = 0;
    int receive_run = 0;

    // Directed text: collapse, byte extremes, strings, both comment forms,
    // a released slash and a slash flushed by the end beat.
    logic [7:0] directed_text [28] = '{
        8'h61, csc_pkg::CH_SPACE, csc_pkg::CH_TAB, csc_pkg::CH_CR, 8'h0C, 8'hFF, 8'h00,
        csc_pkg::CH_QUOTE, csc_pkg::CH_SLASH, csc_pkg::CH_SPACE, csc_pkg::CH_QUOTE,
        csc_pkg::CH_SLASH, csc_pkg::CH_SLASH, csc_pkg::CH_QUOTE, csc_pkg::CH_TAB,
        csc_pkg::CH_NL, csc_pkg::CH_SPACE,
        8'h78, csc_pkg::CH_SPACE, csc_pkg::CH_SLASH, csc_pkg::CH_STAR, csc_pkg::CH_QUOTE,
        csc_pkg::CH_STAR, csc_pkg::CH_SLASH, 8'h0B,
        csc_pkg::CH_SLASH, 8'h71, csc_pkg::CH_SLASH
    };

    comment_strip_space_collapse dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .byte_in   (byte_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .byte_out  (byte_out),
        .end_mark  (end_mark)
    );

    comment_strip_space_collapse_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .byte_in    (byte_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .byte_out   (byte_out),
        .end_mark   (end_mark),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle length: mostly none or short, a few long, with occasional gap-free runs.
    function automatic int pick_gap(inout int run);
        int r;
        if (run > 0)
        begin
            run--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            run = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return csc_pkg::CH_SPACE;
        return 8'(8'h08 + r);
    endfunction

    // Bytes for the inside of strings and comments, biased toward lexer characters.
    function automatic logic [7:0] pick_content();
        case ($urandom_range(0, 7))
            0:       return csc_pkg::CH_SPACE;
            1:       return csc_pkg::CH_TAB;
            2:       return csc_pkg::CH_SLASH;
            3:       return csc_pkg::CH_STAR;
            4:       return csc_pkg::CH_QUOTE;
            5:       return csc_pkg::CH_NL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one input beat and return right after the edge that accepts it.
    task automatic send_beat(input logic k, input logic [7:0] b);
        int gap;
        gap = pick_gap(send_run);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        byte_in  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    // Stop offering beats until every predicted result has been taken.
    task automatic drain_output();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // One lexical token of random text.
    task automatic send_token();
        int len;
        case ($urandom_range(0, 11))
            0, 1:
            begin
                len = $urandom_range(1, 6);
                repeat (len) send_beat(csc_pkg::KIND_DATA, 8'($urandom_range(8'h61, 8'h7A)));
            end
            2:
            begin
                len = $urandom_range(1, 4);
                repeat (len) send_beat(csc_pkg::KIND_DATA, pick_blank());
            end
            3:
            begin
                len = $urandom_range(0, 8);
                send_beat(csc_pkg::KIND_DATA, csc_pkg::CH_QUOTE);
                repeat (len) send_beat(csc_pkg::KIND_DATA, pick_content());
                if ($urandom_range(0, 7) != 0)
                    send_beat(csc_pkg::KIND_DATA, csc_pkg::CH_QUOTE);
            end
            4:
            begin
                len = $urandom_range(0, 8);
                send_beat(csc_pkg::KIND_DATA, csc_pkg::CH_SLASH);
                send_beat(csc_pkg::KIND_DATA, csc_pkg::CH_SLASH);
                repeat (len) send_beat(csc_pkg::KIND_DATA, pick_content());
                if ($urandom_range(0, 5) != 0)
                    send_beat(csc_pkg::KIND_DATA, csc_pkg::CH_NL);
            end
            5:
            begin
                len = $urandom_range(0, 8);
                send_beat(csc_pkg::KIND_DATA, csc_pkg::CH_SLASH);
                send_beat(csc_pkg::KIND_DATA, csc_pkg::CH_STAR);
                repeat (len) send_beat(csc_pkg::KIND_DATA, pick_content());
                if ($urandom_range(0, 5) != 0)
                begin
                    send_beat(csc_pkg::KIND_DATA, csc_pkg::CH_STAR);
                    send_beat(csc_pkg::KIND_DATA, csc_pkg::CH_SLASH);
                end
            end
            6:
            begin
                send_beat(csc_pkg::KIND_DATA, csc_pkg::CH_SLASH);
                send_beat(csc_pkg::KIND_DATA, pick_content());
            end
            7, 8:
            begin
                send_beat(csc_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
            end
            9:
            begin
                len = $urandom_range(1, 4);
                repeat (len) send_beat(csc_pkg::KIND_DATA, pick_content());
            end
            10:
            begin
                send_beat(csc_pkg::KIND_DATA, 8'($urandom_range(8'h41, 8'h5A)));
                send_beat(csc_pkg::KIND_DATA, csc_pkg::CH_SPACE);
            end
            default:
            begin
                if ($urandom_range(0, 2) == 0)
                    send_beat(csc_pkg::KIND_END, 8'($urandom_range(0, 255)));
                else
                    send_beat(csc_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic drained_mid;
        drained_mid = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_text[i])
            send_beat(csc_pkg::KIND_DATA, directed_text[i]);
        send_beat(csc_pkg::KIND_END, 8'hA5);
        drain_output();

        // Random token streams.
        while (beats_sent < 1300)
        begin
            if (!drained_mid && (beats_sent > 650))
            begin
                drain_output();
                drained_mid = 1'b1;
            end
            send_token();
        end
        send_beat(csc_pkg::KIND_END, 8'h00);

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if ((fail_count == 0) && (pending == 0))
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Output side: random back-pressure plus two long holds that fill the block.
    initial
    begin
        int taken;
        int hold;
        taken = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if ((taken == 150) || (taken == 600))
                hold = 400;
            else
                hold = pick_gap(receive_run);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            taken++;
        end
    end

    // Watchdog.
    initial
    begin
        #12_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
